@@ rtl/differential_drive_pose_update_core_assert.svh @@
// assertion macros for the pose update core
`ifndef DIFFERENTIAL_DRIVE_POSE_UPDATE_CORE_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_POSE_UPDATE_CORE_ASSERT_SVH
`define DDP_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DDP_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/ddpu_pkg.sv @@
// shared types, constants and tables of the pose update core
package ddpu_pkg;
  localparam int unsigned MaxSteps = 32;
  localparam logic [31:0] GainInv = 32'd652032874;
  localparam logic [31:0] OneQ30 = 32'h4000_0000;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2,
    DIR_STOP3 = 2'd3
  } dir_t;

  typedef enum logic [0:0] {
    REG_FULL_SPEED = 1'b0,
    REG_HALF_TRACK = 1'b1
  } reg_idx_t;

  // classified tick: signed wheel sum and difference times step
  typedef struct packed {
    logic signed [42:0] num_sum;
    logic signed [42:0] num_dif;
  } tick_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIST, ST_ROT, ST_TRIG, ST_MULX, ST_MULY, ST_ADD, ST_DIV,
    ST_SQRT, ST_VEC, ST_OUT
  } state_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage

@@ rtl/ddpu_front.sv @@
// front end: wheel speeds, classified tick words into a two-entry queue
module ddpu_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_left_cmd,
  input  logic [7:0]             in_right_cmd,
  input  logic [1:0]             in_left_dir,
  input  logic [1:0]             in_right_dir,
  input  logic [15:0]            in_step_time,
  input  logic [15:0]            full_speed,
  output logic                   q_valid,
  input  logic                   q_ready,
  output ddpu_pkg::tick_t        q_data
);
  import ddpu_pkg::*;

  // stage 1: wheel values
  logic               s1_v_r;
  logic signed [25:0] sl_r, sr_r;
  logic [15:0]        dt_r;
  logic [1:0]         cnt_r;
  tick_t              q_r [2];
  logic               wp_r, rp_r;
  logic signed [25:0] slw, srw;
  logic [23:0]        vl, vr;
  logic signed [26:0] ssum, sdif;
  tick_t              tk;
  logic               push, pop;

  assign vl = full_speed * in_left_cmd;
  assign vr = full_speed * in_right_cmd;
  always_comb begin
    case (dir_t'(in_left_dir))
      DIR_FWD: slw = $signed({2'b0, vl});
      DIR_REV: slw = -$signed({2'b0, vl});
      default: slw = '0;
    endcase
    case (dir_t'(in_right_dir))
      DIR_FWD: srw = $signed({2'b0, vr});
      DIR_REV: srw = -$signed({2'b0, vr});
      default: srw = '0;
    endcase
  end

  // stage 1 may hold one word while queue has room for it
  assign in_ready = !s1_v_r || (cnt_r != 2'd2);
  assign push = s1_v_r && (cnt_r != 2'd2);
  assign pop = q_valid && q_ready;

  assign ssum = 27'(sl_r) + 27'(sr_r);
  assign sdif = 27'(sr_r) - 27'(sl_r);
  assign tk.num_sum = ssum * $signed({1'b0, dt_r});
  assign tk.num_dif = sdif * $signed({1'b0, dt_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) s1_v_r <= 1'b1;
      else if (push) s1_v_r <= 1'b0;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sl_r <= slw;
      sr_r <= srw;
      dt_r <= in_step_time;
    end
    if (push) q_r[wp_r] <= tk;
  end

  assign q_valid = cnt_r != 2'd0;
  assign q_data = q_r[rp_r];
endmodule

@@ rtl/ddpu_back.sv @@
// back end: cordic sin/cos, distance, arcsine and pose registers
module ddpu_back #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  ddpu_pkg::tick_t        q_data,
  input  logic [15:0]            half_track,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     out_pos_x,
  output logic signed [31:0]     out_pos_y,
  output logic [31:0]            out_heading
);
  import ddpu_pkg::*;
  localparam int unsigned NIt = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam logic [5:0] LastIt = 6'(NIt - 1);

  state_t state_r, state_nxt;
  tick_t  tk_r;
  logic [5:0] it_r;
  // shared divider / sqrt registers
  logic [63:0] rem_r, quo_r, bit_r, dvs_r;
  logic signed [35:0] cx_r, cy_r;
  logic signed [34:0] cz_r;
  logic signed [33:0] dist_r;
  logic signed [31:0] cs_r, sn_r;
  logic signed [33:0] dx_r, dy_r;
  logic [31:0] amag_r;
  logic        neg_r;
  logic signed [31:0] px_r, py_r;
  logic [31:0] hd_r;
  logic        ov_r;
  logic [4:0]  ii;
  logic [31:0] at;
  logic signed [35:0] xs, ys;
  logic [65:0] dm;
  logic [33:0] dmag;
  logic [31:0] fmag;
  logic [37:0] rnd;
  logic signed [32:0] c_cl, s_cl;
  logic signed [32:0] xq, yq;
  logic signed [34:0] sx, sy;
  logic [63:0] trial;
  logic [63:0] qfin;

  assign ii = it_r[4:0];
  assign at = atan_lut(ii);
  assign xs = cx_r >>> ii;
  assign ys = cy_r >>> ii;

  function automatic logic signed [32:0] clampq(input logic signed [35:0] v);
    logic signed [32:0] r;
    if (v > 36'sd1073741824) r = 33'sd1073741824;
    else if (v < -36'sd1073741824) r = -33'sd1073741824;
    else r = 33'(v);
    return r;
  endfunction

  assign c_cl = clampq(cx_r);
  assign s_cl = clampq(cy_r);
  always_comb begin
    case (hd_r[31:30])
      2'd0: begin xq = c_cl; yq = s_cl; end
      2'd1: begin xq = -s_cl; yq = c_cl; end
      2'd2: begin xq = -c_cl; yq = -s_cl; end
      default: begin xq = s_cl; yq = -c_cl; end
    endcase
  end

  // one 34x32 product, dist times cos or sin
  assign dmag = dist_r[33] ? 34'(-dist_r) : 34'(dist_r);
  assign fmag = 32'((state_r == ST_MULX) ? (cs_r[31] ? -cs_r : cs_r)
                                         : (sn_r[31] ? -sn_r : sn_r));
  assign dm = dmag * fmag;
  assign rnd = 38'((dm + (66'd1 << 37)) >> 38);
  assign sx = 35'(px_r) + 35'(dx_r);
  assign sy = 35'(py_r) + 35'(dy_r);
  assign trial = quo_r + bit_r;
  // divide by 255 finishes with one extra count when the residue is 255
  assign qfin = quo_r + {63'd0, rem_r[7:0] == 8'hFF};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid && !ov_r) state_nxt = ST_DIST;
      ST_DIST: if (rem_r[63:8] == 56'd0) state_nxt = ST_ROT;
      ST_ROT:  if (it_r == LastIt) state_nxt = ST_TRIG;
      ST_TRIG: state_nxt = ST_MULX;
      ST_MULX: state_nxt = ST_MULY;
      ST_MULY: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DIV;
      ST_DIV:  if (bit_r == 64'd0) state_nxt = ST_SQRT;
      ST_SQRT: if (bit_r == 64'd0) state_nxt = ST_VEC;
      ST_VEC:  if (amag_r == 32'd0 || it_r == LastIt) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign q_ready = (state_r == ST_IDLE) && !ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (state_r == ST_ADD) begin
        px_r <= (sx > 35'sd2147483647) ? 32'sh7fffffff :
                (sx < -35'sd2147483648) ? 32'sh80000000 : 32'(sx);
        py_r <= (sy > 35'sd2147483647) ? 32'sh7fffffff :
                (sy < -35'sd2147483648) ? 32'sh80000000 : 32'(sy);
      end
      if (state_r == ST_OUT) begin
        hd_r <= hd_r + (neg_r ? 32'(-cz_r) : 32'(cz_r));
        ov_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        tk_r <= q_data;
        // |num_sum| / 510 as (|num_sum| >> 1) / 255
        rem_r <= 64'(q_data.num_sum[42] ? -q_data.num_sum : q_data.num_sum) >> 1;
        quo_r <= '0;
      end
      ST_DIST: begin
        // 256a + b = 255a + (a + b): fold the high part into the quotient
        if (rem_r[63:8] != 56'd0) begin
          quo_r <= quo_r + (rem_r >> 8);
          rem_r <= (rem_r >> 8) + 64'(rem_r[7:0]);
        end else begin
          dist_r <= tk_r.num_sum[42] ? -34'(qfin) : 34'(qfin);
          cx_r <= 36'(GainInv);
          cy_r <= '0;
          cz_r <= 35'(hd_r[29:0]);
          it_r <= '0;
        end
      end
      ST_ROT: begin
        if (!cz_r[34]) begin
          cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - 35'(at);
        end else begin
          cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + 35'(at);
        end
        it_r <= it_r + 6'd1;
      end
      ST_TRIG: begin
        cs_r <= 32'(xq);
        sn_r <= 32'(yq);
      end
      ST_MULX: begin
        dx_r <= ((dist_r[33]) != (cs_r[31])) ? -34'(rnd) : 34'(rnd);
      end
      ST_MULY: begin
        dy_r <= ((dist_r[33]) != (sn_r[31])) ? -34'(rnd) : 34'(rnd);
      end
      ST_ADD: begin
        neg_r <= tk_r.num_dif[42];
        rem_r <= 64'(tk_r.num_dif[42] ? -tk_r.num_dif : tk_r.num_dif) << 13;
        dvs_r <= (64'd255 * 64'(half_track == 16'd0 ? 16'd1 : half_track)) << 31;
        bit_r <= 64'd1 << 31;
        quo_r <= '0;
      end
      ST_DIV: begin
        if (rem_r >= dvs_r && bit_r != 0) begin
          rem_r <= rem_r - dvs_r;
          quo_r <= quo_r | bit_r;
        end
        dvs_r <= dvs_r >> 1;
        bit_r <= bit_r >> 1;
        if (bit_r == 64'd0) begin
          amag_r <= (quo_r > 64'(OneQ30)) ? OneQ30 : 32'(quo_r);
          rem_r <= (64'd1 << 60) - ((quo_r > 64'(OneQ30)) ? (64'd1 << 60)
                   : 64'(quo_r[30:0]) * 64'(quo_r[30:0]));
          quo_r <= '0;
          bit_r <= 64'd1 << 60;
        end
      end
      ST_SQRT: begin
        if (rem_r >= trial && bit_r != 0) begin
          rem_r <= rem_r - trial;
          quo_r <= (quo_r >> 1) + bit_r;
        end else quo_r <= quo_r >> 1;
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd0) begin
          cx_r <= 36'(quo_r);
          cy_r <= 36'(amag_r);
          cz_r <= '0;
          it_r <= '0;
        end
      end
      ST_VEC: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + 35'(at);
        end else begin
          cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - 35'(at);
        end
        it_r <= it_r + 6'd1;
        if (amag_r == 32'd0) cz_r <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_pos_x = px_r;
  assign out_pos_y = py_r;
  assign out_heading = hd_r;
endmodule

@@ rtl/differential_drive_pose_update_core.sv @@
// a word passes the distance divide by 510, the cordic rotation, the divide, the square
// root and the vectoring, which can end early, plus the control states
// one word is in flight in the back end at a time
// the front end queues two words so the input is taken while the back end works
// synchronous active-low reset clears pose to zero and registers to 3277
module differential_drive_pose_update_core #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_left_cmd,
  input  logic [7:0]         in_right_cmd,
  input  logic [1:0]         in_left_dir,
  input  logic [1:0]         in_right_dir,
  input  logic [15:0]        in_step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ddpu_pkg::*;
  logic [15:0] fs_r, ht_r;
  logic q_valid, q_ready;
  tick_t q_data;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= 16'd3277;
      ht_r <= 16'd3277;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_FULL_SPEED: fs_r <= pwdata[15:0];
        REG_HALF_TRACK: ht_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[1:0] != 2'b00) ? 32'd0 :
                  (paddr[2] == REG_HALF_TRACK) ? {16'd0, ht_r} : {16'd0, fs_r};

  ddpu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_left_cmd, .in_right_cmd,
    .in_left_dir, .in_right_dir, .in_step_time, .full_speed(fs_r),
    .q_valid, .q_ready, .q_data
  );

  ddpu_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .half_track(ht_r),
    .out_valid, .out_ready, .out_pos_x, .out_pos_y, .out_heading
  );
endmodule

@@ rtl/ddpu_checker.sv @@
// port-level checks for the pose update core, bound to the top level
`include "differential_drive_pose_update_core_assert.svh"
module ddpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_heading,
  input logic        pready
);
  `DDP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_heading))
  `DDP_ASSERT_IMP(a_pready, 1'b1, pready)
  `DDP_ASSERT_NXT(a_one_out, out_valid && out_ready, !out_valid)
endmodule

bind differential_drive_pose_update_core ddpu_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_heading, .pready
);
